FILE: rtl/ile_pkg.sv
`timescale 1ns / 1ps
package ile_pkg;
  localparam int Depth  = 64;
  localparam int ItemW  = 32;
  localparam int IdxW   = 6;
  localparam int CntW   = 7;

  typedef enum logic [3:0] {
    REQ_ADD = 4'd0, REQ_INSERT = 4'd1, REQ_DELETE = 4'd2, REQ_GET = 4'd3,
    REQ_PUT = 4'd4, REQ_SEARCH = 4'd5, REQ_REMOVE = 4'd6, REQ_EXCHANGE = 4'd7,
    REQ_MOVE = 4'd8, REQ_CLEAR = 4'd9, REQ_PACK = 4'd10
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BOUNDS = 3'd1, ST_FULL = 3'd2, ST_MISSING = 3'd3,
    ST_DUP_REFUSED = 3'd4, ST_DUP_IGNORED = 3'd5
  } status_e;

  localparam logic [1:0] DupIgnore = 2'd0;
  localparam logic [1:0] DupAccept = 2'd1;
  localparam logic [1:0] DupRefuse = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_RD1, S_RD2, S_WR2, S_PACK, S_DONE
  } state_e;
endpackage

FILE: rtl/indexed_list_engine.sv
`timescale 1ns / 1ps
// Ordered list of up to 64 32-bit words held in one single-port-write,
// registered-read RAM, plus a fill count. One request word in, one result
// word out. Search, add, remove and pack step through the RAM one entry
// per read; insert and delete shift by reading then writing each entry;
// move is a delete followed by an insert; get, put and exchange touch only
// the addressed entries, and clear only resets the count. The result sits
// in an output register; the next request is taken once it is accepted
// downstream.
module indexed_list_engine import ile_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] req_type, [9:4] index, [15:10] index_b, [47:16] item
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [34:3] out_item, [40:35] out_index, [47:41] list_count
  output logic [47:0] m_axis_tdata
);
  logic [ItemW-1:0] mem [Depth];
  logic [ItemW-1:0] rdata_q;
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [ItemW-1:0] wdata;
  logic             re;

  state_e state_q, state_d;
  logic [1:0]  dup_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]  req_q, req_d;
  logic [IdxW-1:0] ia_q, ia_d, ib_q, ib_d;
  logic [ItemW-1:0] item_q, item_d;
  logic [CntW-1:0] p_q, p_d;     // walk pointer
  logic [CntW-1:0] w_q, w_d;     // pack write pointer / aux
  logic [ItemW-1:0] hold_q, hold_d; // carried word
  logic        ph_q, ph_d;       // read/write phase of a shift
  logic        pend_q, pend_d;   // read issued last cycle
  logic [2:0]  st_q, st_d;
  logic [ItemW-1:0] oitem_q, oitem_d;
  logic [IdxW-1:0] oidx_q, oidx_d;
  logic        mvup_q, mvup_d;   // move: second phase inserts

  // memory
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q <= DupIgnore;
    end else if (cfg_we_i) begin
      dup_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; ia_q <= ia_d; ib_q <= ib_d; item_q <= item_d;
    p_q <= p_d; w_q <= w_d; hold_q <= hold_d; ph_q <= ph_d;
    st_q <= st_d; oitem_q <= oitem_d; oidx_q <= oidx_d; mvup_q <= mvup_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_DONE);
  assign m_axis_tdata  = {cnt_q, oidx_q, oitem_q, st_q};

  logic [CntW-1:0] ia_x;
  assign ia_x = {1'b0, ia_q};

  // next state and datapath
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; req_d = req_q; ia_d = ia_q; ib_d = ib_q;
    item_d = item_q; p_d = p_q; w_d = w_q; hold_d = hold_q; ph_d = ph_q;
    pend_d = 1'b0; st_d = st_q; oitem_d = oitem_q; oidx_d = oidx_q;
    mvup_d = mvup_q;
    we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d = s_axis_tdata[3:0];
          ia_d = s_axis_tdata[9:4];
          ib_d = s_axis_tdata[15:10];
          item_d = s_axis_tdata[47:16];
          st_d = ST_OK; oitem_d = '0; oidx_d = '0; p_d = '0; w_d = '0;
          mvup_d = 1'b0; ph_d = 1'b0;
          state_d = S_DONE;
          case (s_axis_tdata[3:0])
            REQ_ADD, REQ_SEARCH, REQ_REMOVE, REQ_PACK: state_d = S_SCAN;
            REQ_INSERT: begin
              if ({1'b0, s_axis_tdata[9:4]} > cnt_q) st_d = ST_BOUNDS;
              else if (cnt_q >= CntW'(Depth)) st_d = ST_FULL;
              else begin
                p_d = cnt_q; state_d = S_SHUP;
              end
            end
            REQ_DELETE, REQ_GET, REQ_PUT: begin
              if ({1'b0, s_axis_tdata[9:4]} >= cnt_q) st_d = ST_BOUNDS;
              else if (s_axis_tdata[3:0] == REQ_PUT) begin
                we = 1'b1; waddr = s_axis_tdata[9:4]; wdata = s_axis_tdata[47:16];
              end else state_d = S_RD1;
            end
            REQ_EXCHANGE: begin
              if ({1'b0, s_axis_tdata[9:4]} >= cnt_q ||
                  {1'b0, s_axis_tdata[15:10]} >= cnt_q) st_d = ST_BOUNDS;
              else state_d = S_RD1;
            end
            REQ_MOVE: begin
              if (s_axis_tdata[9:4] != s_axis_tdata[15:10]) begin
                if ({1'b0, s_axis_tdata[9:4]} >= cnt_q ||
                    {1'b0, s_axis_tdata[15:10]} >= cnt_q) st_d = ST_BOUNDS;
                else state_d = S_RD1;
              end
            end
            REQ_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      // linear walk: read entry p, compare next cycle
      S_SCAN: begin
        if (pend_q && rdata_q == item_q && req_q != REQ_PACK) begin
          // match at p-1
          oidx_d = IdxW'(p_q - 1'b1);
          state_d = S_DONE;
          if (req_q == REQ_ADD) begin
            if (dup_q == DupAccept) begin
              if (cnt_q >= CntW'(Depth)) begin st_d = ST_FULL; oidx_d = '0; end
              else begin
                we = 1'b1; waddr = IdxW'(cnt_q); wdata = item_q;
                oidx_d = IdxW'(cnt_q); cnt_d = cnt_q + 1'b1;
              end
            end else begin
              oidx_d = '0;
              st_d = (dup_q == DupRefuse) ? ST_DUP_REFUSED : ST_DUP_IGNORED;
            end
          end else if (req_q == REQ_REMOVE) begin
            ia_d = IdxW'(p_q - 1'b1); p_d = p_q - 1'b1; state_d = S_SHDN;
          end
        end else if (pend_q && req_q == REQ_PACK && rdata_q != '0) begin
          we = 1'b1; waddr = IdxW'(w_q); wdata = rdata_q; w_d = w_q + 1'b1;
        end
        if (state_d == S_SCAN) begin
          if (p_q < cnt_q) begin
            re = 1'b1; raddr = IdxW'(p_q); pend_d = 1'b1; p_d = p_q + 1'b1;
          end else if (!(pend_q && req_q == REQ_PACK && rdata_q != '0) &&
                       !pend_q || req_q == REQ_PACK && pend_q) begin
            state_d = S_DONE;
            case (req_q)
              REQ_PACK: cnt_d = (pend_q && rdata_q != '0) ? w_q + 1'b1 : w_q;
              REQ_ADD: begin
                if (cnt_q >= CntW'(Depth)) st_d = ST_FULL;
                else begin
                  we = 1'b1; waddr = IdxW'(cnt_q); wdata = item_q;
                  oidx_d = IdxW'(cnt_q); cnt_d = cnt_q + 1'b1;
                end
              end
              default: st_d = ST_MISSING;
            endcase
          end else if (pend_q) begin
            // last read compared and missed; finish next cycle
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
          if (p_q >= cnt_q && pend_q && req_q != REQ_PACK) state_d = S_SCAN;
        end
      end
      // shift up: move entry p-1 to p down to ia, then write hold/item at ia
      S_SHUP: begin
        if (p_q > ia_x) begin
          if (!ph_q) begin
            re = 1'b1; raddr = IdxW'(p_q - 1'b1); ph_d = 1'b1;
          end else begin
            we = 1'b1; waddr = IdxW'(p_q); wdata = rdata_q;
            p_d = p_q - 1'b1; ph_d = 1'b0;
          end
        end else begin
          we = 1'b1; waddr = ia_q; wdata = mvup_q ? hold_q : item_q;
          cnt_d = cnt_q + 1'b1; state_d = S_DONE;
        end
      end
      // shift down: move entry p+1 to p up to count-1
      S_SHDN: begin
        if (p_q + 1'b1 < cnt_q) begin
          if (!ph_q) begin
            re = 1'b1; raddr = IdxW'(p_q + 1'b1); ph_d = 1'b1;
          end else begin
            we = 1'b1; waddr = IdxW'(p_q); wdata = rdata_q;
            p_d = p_q + 1'b1; ph_d = 1'b0;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (req_q == REQ_MOVE) begin
            ia_d = ib_q; p_d = cnt_q - 1'b1; mvup_d = 1'b1; state_d = S_SHUP;
          end else state_d = S_DONE;
        end
      end
      S_RD1: begin
        re = 1'b1; raddr = ia_q; state_d = S_RD2;
      end
      S_RD2: begin
        case (req_q)
          REQ_GET: begin oitem_d = rdata_q; state_d = S_DONE; end
          REQ_DELETE: begin
            oitem_d = rdata_q; p_d = ia_x; state_d = S_SHDN;
          end
          REQ_MOVE: begin
            hold_d = rdata_q; p_d = ia_x; state_d = S_SHDN;
          end
          default: begin // exchange
            hold_d = rdata_q; re = 1'b1; raddr = ib_q; state_d = S_WR2;
          end
        endcase
      end
      S_WR2: begin
        if (!ph_q) begin
          we = 1'b1; waddr = ia_q; wdata = rdata_q; ph_d = 1'b1;
        end else begin
          we = 1'b1; waddr = ib_q; wdata = hold_q; state_d = S_DONE;
        end
      end
      S_DONE: if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end
endmodule
